// ----- src/rbce_pkg.sv -----
// shared types and constants for the refcounted budget cache evictor
// no dependencies
package rbce_pkg;

    localparam int STATUS_W = 4;
    localparam int SLOT_W   = 5;
    localparam int USED_W   = 29;
    localparam int BUDGET_W = 30;
    localparam int BYTES_W  = 24;
    localparam int PRIO_W   = 8;
    localparam int REFS_W   = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 4'd0,
        ST_INSERTED = 4'd1,
        ST_NOTHING  = 4'd2,
        ST_MISSING  = 4'd3,
        ST_STEREO   = 4'd4,
        ST_FORMAT   = 4'd5,
        ST_NO_SPACE = 4'd6,
        ST_FULL     = 4'd7,
        ST_CLOSED   = 4'd8,
        ST_UNKNOWN  = 4'd9
    } status_t;

    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    localparam logic REC_EVICT = 1'b0;
    localparam logic REC_FINAL = 1'b1;

    localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};
    localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // capture request, clear scan state
        OP_SCAN_HIT,  // examine slot for key match
        OP_HIT,       // bump refs on hit slot
        OP_CLOSE,     // decrement refs on close slot
        OP_PASS1,     // idle pass candidate
        OP_PASS2,     // busy lower-priority candidate
        OP_EVICT,     // evict slot at scan index if picked
        OP_FREE,      // look for free slot
        OP_INSERT     // write new entry
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       clr_idx;
        logic       inc_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic       idx_end;      // scan index at last slot
        logic       hit;          // current slot matches key
        logic       close_ok;     // close slot valid
        logic       over_budget;  // new total exceeds budget
        logic       covered;      // freed bytes cover need
        logic       picked;       // current slot picked
        logic       free_here;    // current slot free
        logic       found_free;   // a free slot was recorded
    } dp_stat_t;

endpackage

// ----- src/rbce_datapath.sv -----
// entry table, byte accounting and scan index for the evictor
// depends on rbce_pkg
module rbce_datapath #(
    parameter int TABLE_SLOTS = 32,
    parameter int KEY_BITS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rbce_pkg::dp_cmd_t             cmd,
    output rbce_pkg::dp_stat_t            stat,
    input  logic                          cfg_valid,
    input  logic [rbce_pkg::BUDGET_W-1:0] cfg_data,
    input  logic [15:0]                   item_key,
    input  logic [4:0]                    close_slot,
    input  logic [23:0]                   item_bytes,
    input  logic [7:0]                    item_priority,
    output logic [rbce_pkg::SLOT_W-1:0]   idx_out,
    output logic [rbce_pkg::SLOT_W-1:0]   close_out,
    output logic [rbce_pkg::SLOT_W-1:0]   free_out,
    output logic                          forced_out,
    output logic [rbce_pkg::USED_W-1:0]   used_out
);
    import rbce_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int KW = (KEY_BITS < 16) ? KEY_BITS : 16;

    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [TABLE_SLOTS-1:0] pick_reg, pick_next;
    logic [KEY_BITS-1:0]    key_reg   [TABLE_SLOTS];
    logic [BYTES_W-1:0]     bytes_reg [TABLE_SLOTS];
    logic [REFS_W-1:0]      refs_reg  [TABLE_SLOTS];
    logic [PRIO_W-1:0]      prio_reg  [TABLE_SLOTS];

    logic [USED_W-1:0]   used_reg, used_next;
    logic [BUDGET_W-1:0] budget_reg;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [KEY_BITS-1:0] rkey_reg;
    logic [4:0]          rslot_reg;
    logic [BYTES_W-1:0]  rbytes_reg;
    logic [PRIO_W-1:0]   rprio_reg;
    logic [USED_W:0]     got_reg, got_next;
    logic [IW-1:0]       free_reg;
    logic                found_reg;

    logic [USED_W-1:0] budget_cap;
    logic [USED_W:0]   total;
    logic [USED_W:0]   need;
    logic [IW-1:0]     cidx;
    logic              close_in_range;

    assign budget_cap = (budget_reg > BUDGET_W'(USED_MAX)) ? USED_MAX
                      : budget_reg[USED_W-1:0];
    assign total = {1'b0, used_reg} + (USED_W+1)'(rbytes_reg);
    // excess over the budget, stable while the candidate passes run
    assign need = total - {1'b0, budget_cap};
    assign close_in_range = {1'b0, rslot_reg} < 6'(TABLE_SLOTS);
    assign cidx = IW'(rslot_reg);

    always_comb
    begin
        stat.idx_end     = (idx_reg == IW'(TABLE_SLOTS - 1));
        stat.hit         = valid_reg[idx_reg] && (key_reg[idx_reg] == rkey_reg);
        stat.close_ok    = close_in_range && valid_reg[cidx];
        stat.over_budget = total > {1'b0, budget_cap};
        stat.covered     = got_reg >= need;
        stat.picked      = pick_reg[idx_reg];
        stat.free_here   = !valid_reg[idx_reg];
        stat.found_free  = found_reg;
    end

    assign idx_out    = SLOT_W'(idx_reg);
    assign close_out  = rslot_reg;
    assign free_out   = SLOT_W'(free_reg);
    assign forced_out = refs_reg[idx_reg] != '0;
    // total as it stands after this cycle's update
    assign used_out   = used_next;

    always_comb
    begin
        valid_next = valid_reg;
        pick_next  = pick_reg;
        used_next  = used_reg;
        got_next   = got_reg;
        idx_next   = idx_reg;
        if (cmd.clr_idx)
            idx_next = '0;
        else if (cmd.inc_idx)
            idx_next = idx_reg + 1'b1;
        unique case (cmd.op)
            OP_LOAD:
            begin
                pick_next = '0;
                got_next  = '0;
            end
            OP_PASS1:
                if (!stat.covered && valid_reg[idx_reg] && refs_reg[idx_reg] == '0)
                begin
                    pick_next[idx_reg] = 1'b1;
                    got_next = got_reg + (USED_W+1)'(bytes_reg[idx_reg]);
                end
            OP_PASS2:
                if (!stat.covered && valid_reg[idx_reg] && !pick_reg[idx_reg]
                    && refs_reg[idx_reg] != '0 && prio_reg[idx_reg] < rprio_reg)
                begin
                    pick_next[idx_reg] = 1'b1;
                    got_next = got_reg + (USED_W+1)'(bytes_reg[idx_reg]);
                end
            OP_EVICT:
                if (pick_reg[idx_reg])
                begin
                    valid_next[idx_reg] = 1'b0;
                    used_next = (used_reg >= USED_W'(bytes_reg[idx_reg]))
                              ? used_reg - USED_W'(bytes_reg[idx_reg]) : '0;
                end
            OP_INSERT:
            begin
                valid_next[free_reg] = 1'b1;
                used_next = total[USED_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            used_reg   <= '0;
            budget_reg <= '0;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            idx_reg   <= idx_next;
            if (cfg_valid)
                budget_reg <= cfg_data;
            if (cmd.op == OP_LOAD)
                found_reg <= 1'b0;
            else if (cmd.op == OP_FREE && stat.free_here && !found_reg)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        got_reg  <= got_next;
        if (cmd.op == OP_LOAD)
        begin
            rkey_reg   <= KEY_BITS'(item_key[KW-1:0]);
            rslot_reg  <= close_slot;
            rbytes_reg <= item_bytes;
            rprio_reg  <= item_priority;
        end
        if (cmd.op == OP_FREE && stat.free_here && !found_reg)
            free_reg <= idx_reg;
        if (cmd.op == OP_HIT && refs_reg[idx_reg] != REFS_MAX)
            refs_reg[idx_reg] <= refs_reg[idx_reg] + 1'b1;
        if (cmd.op == OP_CLOSE && refs_reg[cidx] != '0)
            refs_reg[cidx] <= refs_reg[cidx] - 1'b1;
        if (cmd.op == OP_INSERT)
        begin
            key_reg[free_reg]   <= rkey_reg;
            bytes_reg[free_reg] <= rbytes_reg;
            refs_reg[free_reg]  <= REFS_W'(1);
            prio_reg[free_reg]  <= rprio_reg;
        end
    end

endmodule

// ----- src/rbce_ctrl.sv -----
// request sequencer and result register for the evictor
// depends on rbce_pkg
module rbce_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic                        portion_done,
    input  logic                        file_found,
    input  logic                        positional,
    input  logic [3:0]                  channel_count,
    input  logic [1:0]                  format_code,
    output rbce_pkg::dp_cmd_t           cmd,
    input  rbce_pkg::dp_stat_t          stat,
    input  logic [rbce_pkg::SLOT_W-1:0] idx_in,
    input  logic [rbce_pkg::SLOT_W-1:0] close_in,
    input  logic [rbce_pkg::SLOT_W-1:0] free_in,
    input  logic                        forced_in,
    input  logic [rbce_pkg::USED_W-1:0] used_in,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        record_kind,
    output logic [3:0]                  status,
    output logic [4:0]                  slot_index,
    output logic                        forced_stop,
    output logic [28:0]                 bytes_in_use,
    output logic                        last
);
    import rbce_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHECK  = 11'b00000000010,
        S_SCAN   = 11'b00000000100,
        S_PASS1  = 11'b00000001000,
        S_PASS2  = 11'b00000010000,
        S_DECIDE = 11'b00000100000,
        S_EVICT  = 11'b00001000000,
        S_EVICT2 = 11'b00010000000,
        S_FREE   = 11'b00100000000,
        S_INSERT = 11'b01000000000,
        S_WAIT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic   kind_reg, done_reg, found_reg, stereo_reg, fmt_reg;
    logic   emit, emit_kind, emit_last, emit_forced;
    status_t emit_st;
    logic [SLOT_W-1:0] emit_slot;
    logic   busy_out;

    assign busy_out = out_valid && !out_ready;
    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '{op: OP_NONE, clr_idx: 1'b0, inc_idx: 1'b0};
        emit        = 1'b0;
        emit_kind   = REC_FINAL;
        emit_st     = ST_HIT;
        emit_slot   = '0;
        emit_forced = 1'b0;
        emit_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    cmd.op = OP_LOAD;
                    cmd.clr_idx = 1'b1;
                    state_next = S_CHECK;
                end
            S_CHECK:
                if (!busy_out)
                begin
                    if (kind_reg == KIND_CLOSE)
                    begin
                        emit = 1'b1;
                        if (stat.close_ok)
                        begin
                            cmd.op = OP_CLOSE;
                            emit_st = ST_CLOSED;
                            emit_slot = close_in;
                        end
                        else
                            emit_st = ST_UNKNOWN;
                        state_next = S_IDLE;
                    end
                    else if (done_reg)
                    begin
                        emit = 1'b1;
                        emit_st = ST_NOTHING;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_SCAN;
                end
            S_SCAN:
                if (!busy_out)
                begin
                    if (stat.hit)
                    begin
                        cmd.op = OP_HIT;
                        emit = 1'b1;
                        emit_st = ST_HIT;
                        emit_slot = idx_in;
                        state_next = S_IDLE;
                    end
                    else if (!stat.idx_end)
                        cmd.inc_idx = 1'b1;
                    else
                    begin
                        cmd.clr_idx = 1'b1;
                        if (!found_reg || stereo_reg || fmt_reg)
                        begin
                            emit = 1'b1;
                            emit_st = !found_reg ? ST_MISSING
                                    : (stereo_reg ? ST_STEREO : ST_FORMAT);
                            state_next = S_IDLE;
                        end
                        else
                            state_next = stat.over_budget ? S_PASS1 : S_FREE;
                    end
                end
            S_PASS1:
            begin
                cmd.op = OP_PASS1;
                if (stat.idx_end)
                begin
                    cmd.clr_idx = 1'b1;
                    state_next = S_PASS2;
                end
                else
                    cmd.inc_idx = 1'b1;
            end
            S_PASS2:
            begin
                cmd.op = OP_PASS2;
                if (stat.idx_end)
                begin
                    cmd.clr_idx = 1'b1;
                    state_next = S_DECIDE;
                end
                else
                    cmd.inc_idx = 1'b1;
            end
            S_DECIDE:
                if (!busy_out)
                begin
                    if (!stat.covered)
                    begin
                        emit = 1'b1;
                        emit_st = ST_NO_SPACE;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_EVICT;
                end
            S_EVICT:
                if (!busy_out)
                begin
                    // idle picks leave first, in slot order
                    if (stat.picked && !forced_in)
                    begin
                        cmd.op = OP_EVICT;
                        emit = 1'b1;
                        emit_kind = REC_EVICT;
                        emit_slot = idx_in;
                        emit_forced = forced_in;
                        emit_last = 1'b0;
                    end
                    if (stat.idx_end)
                    begin
                        cmd.clr_idx = 1'b1;
                        state_next = S_EVICT2;
                    end
                    else
                        cmd.inc_idx = 1'b1;
                end
            S_EVICT2:
                if (!busy_out)
                begin
                    // then the busy lower-priority picks, in slot order
                    if (stat.picked && forced_in)
                    begin
                        cmd.op = OP_EVICT;
                        emit = 1'b1;
                        emit_kind = REC_EVICT;
                        emit_slot = idx_in;
                        emit_forced = forced_in;
                        emit_last = 1'b0;
                    end
                    if (stat.idx_end)
                    begin
                        cmd.clr_idx = 1'b1;
                        state_next = S_FREE;
                    end
                    else
                        cmd.inc_idx = 1'b1;
                end
            S_FREE:
            begin
                cmd.op = OP_FREE;
                if (stat.idx_end)
                begin
                    cmd.clr_idx = 1'b1;
                    state_next = S_INSERT;
                end
                else
                    cmd.inc_idx = 1'b1;
            end
            S_INSERT:
                if (!busy_out)
                begin
                    emit = 1'b1;
                    if (stat.found_free || stat.free_here)
                    begin
                        cmd.op = OP_INSERT;
                        emit_st = ST_INSERTED;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        emit_st = ST_FULL;
                        state_next = S_IDLE;
                    end
                end
            S_WAIT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit && !(state_reg == S_INSERT && cmd.op == OP_INSERT))
                out_valid <= 1'b1;
            else if (state_reg == S_WAIT)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            kind_reg   <= kind;
            done_reg   <= portion_done;
            found_reg  <= file_found;
            stereo_reg <= positional && (channel_count > 4'd1);
            fmt_reg    <= format_code > 2'd1;
        end
        if (emit)
        begin
            record_kind <= emit_kind;
            status      <= emit_st;
            slot_index  <= (cmd.op == OP_INSERT) ? free_in : emit_slot;
            forced_stop <= emit_forced;
            last        <= emit_last;
        end
        // bytes follow the total after the datapath update
        if (emit || state_reg == S_WAIT)
            bytes_in_use <= used_in;
    end

endmodule

// ----- src/refcounted_budget_cache_evictor_core.sv -----
// top level of the refcounted budget cache evictor
// depends on rbce_pkg, rbce_ctrl, rbce_datapath
//
// A cache table of TABLE_SLOTS entries under a byte budget. An open scans the
// slots one a cycle for the key. A miss over the budget then runs two candidate
// passes and, if the picks cover the need, two eviction passes (idle picks,
// then busy picks); a miss that may insert runs a free-slot pass. Each pass
// takes one slot a cycle; a record not yet taken stalls the key scan and the
// eviction passes, as a stalled output holds the sequencer. One request is
// worked at a time and the next is taken once the last record has left;
// records leave through an output register, one per transfer, eviction notices
// before the final answer.
module refcounted_budget_cache_evictor_core #(
    parameter int TABLE_SLOTS = 32,
    parameter int KEY_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [29:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] item_key,
    input  logic [4:0]  close_slot,
    input  logic [23:0] item_bytes,
    input  logic [7:0]  item_priority,
    input  logic        portion_done,
    input  logic        file_found,
    input  logic        positional,
    input  logic [3:0]  channel_count,
    input  logic [1:0]  format_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        record_kind,
    output logic [3:0]  status,
    output logic [4:0]  slot_index,
    output logic        forced_stop,
    output logic [28:0] bytes_in_use,
    output logic        last
);
    import rbce_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [SLOT_W-1:0] idx_w, close_w, free_w;
    logic              forced_w;
    logic [USED_W-1:0] used_w;

    // budget write taken every cycle, write it only between requests
    assign cfg_ready = 1'b1;

    rbce_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .item_key(item_key), .close_slot(close_slot), .item_bytes(item_bytes),
        .item_priority(item_priority),
        .idx_out(idx_w), .close_out(close_w), .free_out(free_w),
        .forced_out(forced_w), .used_out(used_w)
    );

    rbce_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .portion_done(portion_done), .file_found(file_found),
        .positional(positional), .channel_count(channel_count),
        .format_code(format_code), .cmd(cmd), .stat(stat),
        .idx_in(idx_w), .close_in(close_w), .free_in(free_w),
        .forced_in(forced_w), .used_in(used_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .record_kind(record_kind), .status(status), .slot_index(slot_index),
        .forced_stop(forced_stop), .bytes_in_use(bytes_in_use), .last(last)
    );

    // no new request while a record is pending
    a_no_accept_with_output: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while record pending");

    // an eviction notice is never the last record
    a_evict_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && record_kind == REC_EVICT) |-> !last)
        else $error("eviction notice flagged last");

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for refcounted_budget_cache_evictor_core
// depends on rbce_pkg and the core; drives requests and budget writes, predicts records
module tb_top;
    import rbce_pkg::*;

    localparam int SLOTS      = 32;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 200;

    // one request as it goes over the input channel
    typedef struct packed {
        logic        kind;
        logic [15:0] key;
        logic [4:0]  cslot;
        logic [23:0] bytes;
        logic [7:0]  prio;
        logic        done;
        logic        found;
        logic        posit;
        logic [3:0]  chans;
        logic [1:0]  fmt;
    } request_t;

    // one output record
    typedef struct packed {
        logic          rkind;
        status_t       st;
        logic [4:0]    slot;
        logic          forced;
        logic [28:0]   used;
        logic          last;
    } record_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [29:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [15:0] item_key;
    logic [4:0]  close_slot;
    logic [23:0] item_bytes;
    logic [7:0]  item_priority;
    logic        portion_done;
    logic        file_found;
    logic        positional;
    logic [3:0]  channel_count;
    logic [1:0]  format_code;
    logic        out_valid;
    logic        out_ready;
    logic        record_kind;
    logic [3:0]  status;
    logic [4:0]  slot_index;
    logic        forced_stop;
    logic [28:0] bytes_in_use;
    logic        last;

    refcounted_budget_cache_evictor_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .item_key(item_key), .close_slot(close_slot),
        .item_bytes(item_bytes), .item_priority(item_priority),
        .portion_done(portion_done), .file_found(file_found),
        .positional(positional), .channel_count(channel_count),
        .format_code(format_code),
        .out_valid(out_valid), .out_ready(out_ready),
        .record_kind(record_kind), .status(status), .slot_index(slot_index),
        .forced_stop(forced_stop), .bytes_in_use(bytes_in_use), .last(last)
    );

    // cache shadow kept by the predictor
    logic        sh_valid [SLOTS];
    logic [15:0] sh_key   [SLOTS];
    logic [23:0] sh_bytes [SLOTS];
    logic [7:0]  sh_refs  [SLOTS];
    logic [7:0]  sh_prio  [SLOTS];
    logic [28:0] sh_used;
    logic [29:0] sh_budget;

    request_t pending_requests [$];
    record_t  expected_records [$];

    int  error_count    = 0;
    int  cycle_count    = 0;
    int  records_seen   = 0;
    int  evictions_seen = 0;
    bit  busy_phase;      // no idling on either side while set
    bit  cfg_req;
    logic [29:0] cfg_next;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d (record %0d)",
                 what, got, want, records_seen);
        error_count++;
    endtask

    task automatic queue_record(input record_t r);
        expected_records = {expected_records, r};
    endtask

    task automatic queue_request(input request_t r);
        pending_requests = {pending_requests, r};
    endtask

    function automatic record_t make_record(logic rk, status_t st, logic [4:0] slot,
                                            logic forced, logic lst);
        record_t r;
        r.rkind  = rk;
        r.st     = st;
        r.slot   = slot;
        r.forced = forced;
        r.used   = sh_used;
        r.last   = lst;
        return r;
    endfunction

    // works out the records one accepted request causes, updating the shadow
    task automatic predict_cache_records(input request_t rq);
        logic [29:0] cap;
        logic [30:0] total;
        logic [30:0] need;
        logic [30:0] got;
        bit          pick [SLOTS];
        int          order [SLOTS];
        int          npick;
        int          free_slot;
        int          s;
        cap = (sh_budget > 30'(USED_MAX)) ? 30'(USED_MAX) : sh_budget;
        npick = 0;
        if (rq.kind == KIND_CLOSE) begin
            if (!sh_valid[rq.cslot]) begin
                queue_record(make_record(REC_FINAL, ST_UNKNOWN, 5'd0, 1'b0, 1'b1));
                return;
            end
            if (sh_refs[rq.cslot] != 8'd0)
                sh_refs[rq.cslot]--;
            queue_record(make_record(REC_FINAL, ST_CLOSED, rq.cslot, 1'b0, 1'b1));
            return;
        end
        if (rq.done) begin
            queue_record(make_record(REC_FINAL, ST_NOTHING, 5'd0, 1'b0, 1'b1));
            return;
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (sh_valid[i] && sh_key[i] == rq.key) begin
                if (sh_refs[i] != REFS_MAX)
                    sh_refs[i]++;
                queue_record(make_record(REC_FINAL, ST_HIT, 5'(i), 1'b0, 1'b1));
                return;
            end
        end
        if (!rq.found) begin
            queue_record(make_record(REC_FINAL, ST_MISSING, 5'd0, 1'b0, 1'b1));
            return;
        end
        if (rq.posit && rq.chans > 4'd1) begin
            queue_record(make_record(REC_FINAL, ST_STEREO, 5'd0, 1'b0, 1'b1));
            return;
        end
        if (rq.fmt > 2'd1) begin
            queue_record(make_record(REC_FINAL, ST_FORMAT, 5'd0, 1'b0, 1'b1));
            return;
        end
        total = 31'(sh_used) + 31'(rq.bytes);
        if (total > 31'(cap)) begin
            need = total - 31'(cap);
            got  = '0;
            for (int i = 0; i < SLOTS; i++)
                pick[i] = 1'b0;
            // idle entries first, then busy ones of lower priority
            for (int i = 0; i < SLOTS && got < need; i++)
                if (sh_valid[i] && sh_refs[i] == 8'd0) begin
                    pick[i] = 1'b1;
                    order[npick] = i;
                    npick++;
                    got += 31'(sh_bytes[i]);
                end
            for (int i = 0; i < SLOTS && got < need; i++)
                if (sh_valid[i] && !pick[i] && sh_refs[i] != 8'd0 && sh_prio[i] < rq.prio) begin
                    pick[i] = 1'b1;
                    order[npick] = i;
                    npick++;
                    got += 31'(sh_bytes[i]);
                end
            if (got < need) begin
                queue_record(make_record(REC_FINAL, ST_NO_SPACE, 5'd0, 1'b0, 1'b1));
                return;
            end
            for (int j = 0; j < npick; j++) begin
                s = order[j];
                sh_used = (sh_used >= 29'(sh_bytes[s])) ? sh_used - 29'(sh_bytes[s]) : 29'd0;
                sh_valid[s] = 1'b0;
                queue_record(make_record(REC_EVICT, ST_HIT, 5'(s),
                                         sh_refs[s] != 8'd0, 1'b0));
            end
        end
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (!sh_valid[i])
                free_slot = i;
        if (free_slot < 0) begin
            queue_record(make_record(REC_FINAL, ST_FULL, 5'd0, 1'b0, 1'b1));
            return;
        end
        sh_valid[free_slot] = 1'b1;
        sh_key[free_slot]   = rq.key;
        sh_bytes[free_slot] = rq.bytes;
        sh_refs[free_slot]  = 8'd1;
        sh_prio[free_slot]  = rq.prio;
        sh_used = sh_used + 29'(rq.bytes);
        queue_record(make_record(REC_FINAL, ST_INSERTED, 5'(free_slot), 1'b0, 1'b1));
    endtask

    function automatic request_t open_req(logic [15:0] key, logic [23:0] bytes,
                                          logic [7:0] prio);
        request_t r;
        r = '0;
        r.kind  = KIND_OPEN;
        r.key   = key;
        r.bytes = bytes;
        r.prio  = prio;
        r.found = 1'b1;
        r.chans = 4'd1;
        return r;
    endfunction

    function automatic request_t close_req(logic [4:0] slot);
        request_t r;
        r = request_t'(63'({$urandom(), $urandom()}));
        r.kind  = KIND_CLOSE;
        r.cslot = slot;
        return r;
    endfunction

    // random request: closes and opens over a small key space, the opens mostly well formed
    function automatic request_t random_req(int key_span, int max_bytes);
        request_t r;
        int sel;
        r = request_t'(63'({$urandom(), $urandom()}));
        sel = $urandom_range(0, 99);
        if (sel < 35) begin
            r = close_req(5'($urandom_range(0, 31)));
        end else if (sel < 85) begin
            r = open_req(16'($urandom_range(0, key_span)), 24'($urandom_range(0, max_bytes)),
                         8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) == 0)
                r.key = 16'($urandom());
            if ($urandom_range(0, 19) == 0)
                r.bytes = 24'($urandom());
            r.posit = 1'($urandom_range(0, 1));
            r.chans = r.posit ? 4'd1 : 4'($urandom_range(1, 8));
            r.fmt   = 2'($urandom_range(0, 1));
        end else begin
            r.kind = KIND_OPEN;
            r.key  = 16'($urandom_range(0, key_span));
            r.fmt  = 2'($urandom());
        end
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            {kind, item_key, close_slot, item_bytes, item_priority, portion_done,
             file_found, positional, channel_count, format_code} <= '0;
            sh_used = '0;
            for (int i = 0; i < SLOTS; i++) begin
                sh_valid[i] = 1'b0; sh_key[i] = '0; sh_bytes[i] = '0;
                sh_refs[i] = '0; sh_prio[i] = '0;
            end
        end else if (!in_valid || in_ready) begin
            if (pending_requests.size() != 0 &&
                (busy_phase || $urandom_range(0, 99) >= 38)) begin
                request_t rq;
                rq = pending_requests.pop_front();
                predict_cache_records(rq);
                in_valid <= 1'b1;
                {kind, item_key, close_slot, item_bytes, item_priority, portion_done,
                 file_found, positional, channel_count, format_code} <= rq;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // budget register writes, only requested while the core is idle
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            cfg_valid <= 1'b0;
        end else if (cfg_req && !cfg_valid) begin
            cfg_valid <= 1'b1;
            cfg_data  <= cfg_next;
        end
    end

    // record monitor and ready throttle
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= busy_phase || $urandom_range(0, 99) >= 38;
            if (out_valid && out_ready) begin
                if (expected_records.size() == 0) begin
                    report_mismatch("unexpected record", 32'(status), 32'd0);
                end else begin
                    record_t want;
                    want = expected_records.pop_front();
                    if (record_kind !== want.rkind)
                        report_mismatch("record_kind", 32'(record_kind), 32'(want.rkind));
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (slot_index !== want.slot)
                        report_mismatch("slot_index", 32'(slot_index), 32'(want.slot));
                    if (forced_stop !== want.forced)
                        report_mismatch("forced_stop", 32'(forced_stop), 32'(want.forced));
                    if (bytes_in_use !== want.used)
                        report_mismatch("bytes_in_use", 32'(bytes_in_use), 32'(want.used));
                    if (last !== want.last)
                        report_mismatch("last", 32'(last), 32'(want.last));
                end
                records_seen++;
                if (record_kind == REC_EVICT)
                    evictions_seen++;
            end
        end
    end

    // timeout watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout with %0d records outstanding", expected_records.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_budget(input logic [29:0] value);
        cfg_next  = value;
        sh_budget = value;
        cfg_req   = 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_req = 1'b0;
    endtask

    initial begin
        request_t rq;
        busy_phase = 1'b0; cfg_req = 1'b0; cfg_next = '0;
        sh_budget = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: budget zero rejects anything with bytes, zero size fits
        queue_request(open_req(16'h0001, 24'd5, 8'd10));
        queue_request(open_req(16'h0002, 24'd0, 8'd0));
        queue_request(close_req(5'd31));
        wait_idle();
        write_budget(30'h3FFF_FFFF);     // above the used width, clipped
        rq = open_req(16'hFFFF, 24'hFF_FFFF, 8'hFF); queue_request(rq);
        rq.done = 1'b1; queue_request(rq);
        rq = open_req(16'h0003, 24'd100, 8'd1); rq.found = 1'b0; queue_request(rq);
        rq.found = 1'b1; rq.posit = 1'b1; rq.chans = 4'd2; queue_request(rq);
        rq.chans = 4'd15; queue_request(rq);
        rq.posit = 1'b0; rq.fmt = 2'd2; queue_request(rq);
        rq.fmt = 2'd3; queue_request(rq);
        rq.fmt = 2'd1; queue_request(rq);
        queue_request(open_req(16'hFFFF, 24'd1, 8'd0));   // hit
        queue_request(close_req(5'd0));
        queue_request(close_req(5'd0));
        queue_request(close_req(5'd0));                    // saturates at zero
        queue_request(close_req(5'd1));
        queue_request(close_req(5'd1));
        wait_idle();
        // small budget forces idle and busy evictions, then no space
        write_budget(30'd300);
        queue_request(open_req(16'h0010, 24'd200, 8'd5));
        queue_request(open_req(16'h0011, 24'd200, 8'd200));
        queue_request(open_req(16'h0012, 24'd250, 8'd100));
        queue_request(open_req(16'h0013, 24'd301, 8'd255));
        wait_idle();
        // fill all slots with zero-size items to reach table full
        write_budget(30'd1000);
        for (int i = 0; i < SLOTS + 1; i++)
            queue_request(open_req(16'(16'h0100 + i), 24'd0, 8'd1));
        wait_idle();

        // random phases over several budgets
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_budget(30'd0);
                1: write_budget(30'd2000);
                2: write_budget(30'($urandom_range(500, 5000)));
                3: write_budget(30'd100000000);
                4: write_budget(30'd1500);
                default: write_budget(30'h3FFF_FFFF);
            endcase
            busy_phase = (ph == 4);
            for (int n = 0; n < 55; n++)
                queue_request(random_req((ph == 3) ? 127 : 47,
                                         (ph >= 3) ? 16777215 : 600));
            wait_idle();
        end
        busy_phase = 1'b0;

        $display("checked %0d records, %0d of them evictions, over directed cases",
                 records_seen, evictions_seen);
        $display("and six random phases with different budgets");
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
